@@ rtl/qeif_pkg.sv @@
`default_nettype none

package qeif_pkg;

    // Field widths of the sample and result items.
    localparam int CMD_W    = 2;
    localparam int NOW_W    = 32;
    localparam int AB_W     = 2;
    localparam int BTN_W    = 6;
    localparam int POS_W    = 16;
    localparam int DELTA_W  = 8;
    localparam int LEVEL_W  = 3;

    // Internal state widths.
    localparam int SUB_W    = 6;
    localparam int DETENT_W = 5;
    localparam int LOCK_W   = 10;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_DETENT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOCKOUT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [DETENT_W-1:0] DETENT_RESET  = 5'd4;
    localparam logic [LOCK_W-1:0]   LOCKOUT_RESET = 10'd50;

    // Number of low buttons that get a millisecond lockout.
    localparam int DEBOUNCED_BUTTONS = 5;

    // Level bit positions.
    localparam int LVL_ESTOP = 0;
    localparam int LVL_GUARD = 1;
    localparam int LVL_PEDAL = 2;

    // Item commands; the unused code changes no state.
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_RESET  = 2'd2
    } t_cmd;

    // Quadrature transition table, indexed by {previous AB, current AB}.
    localparam logic signed [1:0] PHASE_STEP [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

@@ rtl/quadrature_encoder_input_frontend.sv @@
// The result item is registered: it appears in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the single result register is reloaded
// in the same cycle in which its item is taken downstream.
// Reset (i_rst_n low at a clock edge) clears the decoder, button and level
// state, loads the detent size 4 and lockout 50 ms, marks all buttons released
// and empties the result register.
`default_nettype none

module quadrature_encoder_input_frontend #(
    parameter int P_DEBOUNCED_BUTTONS = qeif_pkg::DEBOUNCED_BUTTONS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [qeif_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [qeif_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Sample items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [qeif_pkg::CMD_W-1:0]       i_command,
    input  wire logic [qeif_pkg::NOW_W-1:0]       i_now_ms,
    input  wire logic [qeif_pkg::AB_W-1:0]        i_enc_ab,
    input  wire logic [qeif_pkg::BTN_W-1:0]       i_buttons_n,
    input  wire logic                             i_estop_level,
    input  wire logic                             i_guard_level,
    input  wire logic                             i_pedal_level,
    // Result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [qeif_pkg::POS_W-1:0]     o_position,
    output logic signed [qeif_pkg::DELTA_W-1:0]   o_delta,
    output logic [qeif_pkg::BTN_W-1:0]            o_button_events,
    output logic                                  o_estop_active,
    output logic                                  o_guard_open,
    output logic                                  o_pedal_pressed,
    output logic [qeif_pkg::LEVEL_W-1:0]          o_level_changes,
    output logic                                  o_cut_motor
);

    import qeif_pkg::*;

    localparam int NUM_TS = (P_DEBOUNCED_BUTTONS < BTN_W) ? P_DEBOUNCED_BUTTONS : BTN_W;

    // Configuration registers
    logic [DETENT_W-1:0] r_detent;
    logic [LOCK_W-1:0]   r_lockout;

    // Decoder, button and level state
    logic [AB_W-1:0]           r_prev_ab,   n_prev_ab;
    logic signed [SUB_W-1:0]   r_sub,       n_sub;
    logic [POS_W-1:0]          r_pos,       n_pos;
    logic [DELTA_W-1:0]        r_delta,     n_delta;
    logic [BTN_W-1:0]          r_prev_btn,  n_prev_btn;
    logic [BTN_W-1:0]          r_events,    n_events;
    logic [LEVEL_W-1:0]        r_levels,    n_levels;
    logic [LEVEL_W-1:0]        r_changes,   n_changes;
    logic [NOW_W-1:0]          r_ts [NUM_TS];

    // Result register
    logic                      r_out_valid, n_out_valid;
    logic [POS_W-1:0]          r_res_pos,     n_res_pos;
    logic [DELTA_W-1:0]        r_res_delta,   n_res_delta;
    logic [BTN_W-1:0]          r_res_events,  n_res_events;
    logic [LEVEL_W-1:0]        r_res_levels,  n_res_levels;
    logic [LEVEL_W-1:0]        r_res_changes, n_res_changes;
    logic                      r_res_cut,     n_res_cut;

    logic                      w_take;
    logic                      w_sample;
    logic [BTN_W-1:0]          w_falls;
    logic [BTN_W-1:0]          w_accept;
    logic [LEVEL_W-1:0]        w_lv;

    // The result register frees up in the cycle its item is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_sample   = (t_cmd'(i_command) == CMD_SAMPLE);
    assign w_falls    = r_prev_btn & ~i_buttons_n;
    assign w_lv       = {i_pedal_level, i_guard_level, i_estop_level};

    // Press acceptance per button; the low buttons check their lockout.
    for (genvar g = 0; g < BTN_W; g++) begin : g_btn
        if (g < NUM_TS) begin : g_lock
            logic [NOW_W-1:0] w_age;
            assign w_age = i_now_ms - r_ts[g];
            assign w_accept[g] = w_falls[g] &&
                (w_age >= {{(NOW_W-LOCK_W){1'b0}}, r_lockout});
        end else begin : g_free
            assign w_accept[g] = w_falls[g];
        end
    end

    // Time of the last accepted press of each locked-out button.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TS; i++) begin
                r_ts[i] <= '0;
            end
        end else if (w_take && w_sample) begin
            for (int i = 0; i < NUM_TS; i++) begin
                if (w_accept[i]) begin
                    r_ts[i] <= i_now_ms;
                end
            end
        end
    end

    // Next state and result for one item.
    always_comb begin
        logic signed [1:0]       step;
        logic signed [SUB_W:0]   sum;
        logic signed [SUB_W:0]   size;
        logic [LEVEL_W-1:0]      diff;

        step = PHASE_STEP[{r_prev_ab, i_enc_ab}];
        sum  = {r_sub[SUB_W-1], r_sub} + {{(SUB_W-1){step[1]}}, step};
        size = {2'b00, r_detent};
        diff = w_lv ^ r_levels;

        n_prev_ab  = r_prev_ab;
        n_sub      = r_sub;
        n_pos      = r_pos;
        n_delta    = r_delta;
        n_prev_btn = r_prev_btn;
        n_events   = r_events;
        n_levels   = r_levels;
        n_changes  = r_changes;
        n_res_cut  = 1'b0;

        case (t_cmd'(i_command))
            CMD_SAMPLE: begin
                // Quadrature decode and detent counting.
                n_prev_ab = i_enc_ab;
                if (step != 2'sd0) begin
                    if (sum >= size) begin
                        n_sub   = '0;
                        n_pos   = r_pos + 1'b1;
                        n_delta = r_delta + 1'b1;
                    end else if (sum <= -size) begin
                        n_sub   = '0;
                        n_pos   = r_pos - 1'b1;
                        n_delta = r_delta - 1'b1;
                    end else begin
                        n_sub = sum[SUB_W-1:0];
                    end
                end
                // Button press events.
                n_events   = r_events | w_accept;
                n_prev_btn = i_buttons_n;
                // Level tracking; a rise of e-stop or guard cuts the motor.
                n_changes  = r_changes | diff;
                n_levels   = w_lv;
                n_res_cut  = |(diff[LVL_GUARD:LVL_ESTOP] & w_lv[LVL_GUARD:LVL_ESTOP]);
            end
            CMD_RESET: begin
                n_pos   = '0;
                n_delta = '0;
            end
            default: begin
            end
        endcase

        // The result shows the state before a read clears it.
        n_res_pos     = n_pos;
        n_res_delta   = n_delta;
        n_res_events  = n_events;
        n_res_levels  = n_levels;
        n_res_changes = n_changes;

        if (t_cmd'(i_command) == CMD_READ) begin
            n_delta   = '0;
            n_events  = '0;
            n_changes = '0;
        end

        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent  <= DETENT_RESET;
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DETENT:  r_detent  <= i_cfg_data[DETENT_W-1:0];
                CFG_LOCKOUT: r_lockout <= i_cfg_data[LOCK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State registers, updated when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab  <= '0;
            r_sub      <= '0;
            r_pos      <= '0;
            r_delta    <= '0;
            r_prev_btn <= '1;
            r_events   <= '0;
            r_levels   <= '0;
            r_changes  <= '0;
        end else if (w_take) begin
            r_prev_ab  <= n_prev_ab;
            r_sub      <= n_sub;
            r_pos      <= n_pos;
            r_delta    <= n_delta;
            r_prev_btn <= n_prev_btn;
            r_events   <= n_events;
            r_levels   <= n_levels;
            r_changes  <= n_changes;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res_pos     <= n_res_pos;
            r_res_delta   <= n_res_delta;
            r_res_events  <= n_res_events;
            r_res_levels  <= n_res_levels;
            r_res_changes <= n_res_changes;
            r_res_cut     <= n_res_cut;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_position      = r_res_pos;
    assign o_delta         = r_res_delta;
    assign o_button_events = r_res_events;
    assign o_estop_active  = r_res_levels[LVL_ESTOP];
    assign o_guard_open    = r_res_levels[LVL_GUARD];
    assign o_pedal_pressed = r_res_levels[LVL_PEDAL];
    assign o_level_changes = r_res_changes;
    assign o_cut_motor     = r_res_cut;

endmodule

`default_nettype wire

@@ rtl/qeif_checker.sv @@
`default_nettype none

module qeif_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             o_in_ready,
    input  wire logic [qeif_pkg::CMD_W-1:0]       i_command,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic signed [qeif_pkg::POS_W-1:0]   o_position,
    input  wire logic signed [qeif_pkg::DELTA_W-1:0] o_delta,
    input  wire logic                             o_estop_active,
    input  wire logic                             o_guard_open,
    input  wire logic                             o_cut_motor
);

    import qeif_pkg::*;

    // A stalled result item holds its place and its position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_position))
        else $error("result item dropped or changed while stalled");

    // Only a pin sample can request a motor cut.
    a_cut_only_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command != CMD_SAMPLE)
        |=> o_out_valid && !o_cut_motor)
        else $error("motor cut on a command item");

    // A position reset reports zero position and delta.
    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_RESET)
        |=> o_out_valid && (o_position == '0) && (o_delta == '0))
        else $error("position reset not reflected in result");

    // A motor cut comes with e-stop engaged or the guard open.
    a_cut_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cut_motor |-> o_estop_active || o_guard_open)
        else $error("motor cut without an active e-stop or guard");

endmodule

bind quadrature_encoder_input_frontend qeif_checker u_qeif_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_position     (o_position),
    .o_delta        (o_delta),
    .o_estop_active (o_estop_active),
    .o_guard_open   (o_guard_open),
    .o_cut_motor    (o_cut_motor)
);

`default_nettype wire
